@@ src/shake_gesture_detector_defines.svh @@
// Assertion macros shared by the shake gesture detector sources.
`ifndef SHAKE_GESTURE_DETECTOR_DEFINES_SVH
`define SHAKE_GESTURE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sgd_pkg.sv @@
`default_nettype none

package sgd_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SHAKE_ENABLE = 2'd0,
        CFG_TURN_WINDOW  = 2'd1,
        CFG_MIN_TRAVEL   = 2'd2,
        CFG_TURNS_NEEDED = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 32;
    localparam int MOVE_W     = 16;
    localparam int TIME_W     = 48;
    localparam int POS_W      = 24;
    localparam int TRAVEL_W   = 20;
    localparam int COUNT_W    = 4;
    localparam int WINDOW_W   = 32;
    localparam int MINTRV_W   = 16;

    localparam logic                RST_SHAKE_ENABLE = 1'b1;
    localparam logic [WINDOW_W-1:0] RST_TURN_WINDOW  = 32'd400_000_000;
    localparam logic [MINTRV_W-1:0] RST_MIN_TRAVEL   = 16'd400;
    localparam logic [COUNT_W-1:0]  RST_TURNS_NEEDED = 4'd3;

    localparam logic signed [POS_W-1:0] POS_MAX    = 24'sh7F_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN    = 24'sh80_0000;
    localparam logic [TRAVEL_W-1:0]     TRAVEL_MAX = 20'hF_FFFF;
    localparam logic [COUNT_W-1:0]      COUNT_MAX  = 4'hF;

endpackage

`default_nettype wire

@@ src/shake_gesture_detector.sv @@
// Shake gesture detector.
// The input channel (s_valid/s_ready) carries one pointer movement per word:
// s_cmd selects a relative delta (0) or an absolute position (1), s_movement
// is the signed value and s_timestamp_ns the time of the movement. The result
// channel (m_valid/m_ready) returns exactly one word per input word, with
// m_shaking high when that movement completes a shake gesture.
// A word accepted at one clock edge is registered, evaluated against the
// tracked state at the next edge at which the result slot is free, and its
// result is presented from that edge on until m_ready takes it. One word
// per cycle is sustained while the receiver keeps m_ready high; evaluation
// is a single stage between the input and result registers.
// When the receiver stalls, the result word holds and the input register
// still takes one more word; after that s_ready drops until m_ready returns.
// The user writes configuration through cfg_wr_en/cfg_index/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
// Synchronous active-low reset empties both stages, clears the tracked
// state and loads the default configuration.

`default_nettype none

`include "shake_gesture_detector_defines.svh"

module shake_gesture_detector (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_cmd,
    input  wire logic signed [sgd_pkg::MOVE_W-1:0]    s_movement,
    input  wire logic [sgd_pkg::TIME_W-1:0]           s_timestamp_ns,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_shaking,
    input  wire logic                                 cfg_wr_en,
    input  wire sgd_pkg::cfg_index_t                  cfg_index,
    input  wire logic [sgd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import sgd_pkg::*;

    // Configuration registers.
    logic                shake_enable_reg;
    logic [WINDOW_W-1:0] turn_window_reg;
    logic [MINTRV_W-1:0] min_travel_reg;
    logic [COUNT_W-1:0]  turns_needed_reg;

    // Input stage.
    logic                     in_valid_reg;
    logic                     in_cmd_reg;
    logic signed [MOVE_W-1:0] in_move_reg;
    logic [TIME_W-1:0]        in_time_reg;

    // Result stage.
    logic m_valid_reg;
    logic m_shaking_reg;

    // Tracked gesture state.
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic [TRAVEL_W-1:0]     travel_reg, travel_next;
    logic                    dir_neg_reg, dir_neg_next;
    logic [TIME_W-1:0]       last_time_reg, last_time_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    shake_next;

    // Datapath intermediates.
    logic signed [POS_W:0] move_ext;
    logic signed [POS_W:0] pos_ext;
    logic signed [POS_W:0] delta;
    logic signed [POS_W:0] pos_sum;
    logic signed [POS_W:0] delta_neg;
    logic [POS_W-1:0]      mag;
    logic [POS_W:0]        travel_sum;
    logic [TRAVEL_W-1:0]   travel_sat;
    logic                  reversal;
    logic [TIME_W-1:0]     elapsed;
    logic                  in_window;
    logic [COUNT_W-1:0]    count_inc;

    logic out_free;
    logic fire;

    // The result slot is free when empty or being drained this cycle.
    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = m_valid_reg;
    assign m_shaking = m_shaking_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shake_enable_reg <= RST_SHAKE_ENABLE;
            turn_window_reg  <= RST_TURN_WINDOW;
            min_travel_reg   <= RST_MIN_TRAVEL;
            turns_needed_reg <= RST_TURNS_NEEDED;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SHAKE_ENABLE: shake_enable_reg <= cfg_wdata[0];
                CFG_TURN_WINDOW:  turn_window_reg  <= cfg_wdata[WINDOW_W-1:0];
                CFG_MIN_TRAVEL:   min_travel_reg   <= cfg_wdata[MINTRV_W-1:0];
                CFG_TURNS_NEEDED: turns_needed_reg <= cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_move_reg <= s_movement;
            in_time_reg <= s_timestamp_ns;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_shaking_reg <= shake_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            travel_reg    <= '0;
            dir_neg_reg   <= 1'b0;
            last_time_reg <= '0;
            count_reg     <= '0;
        end else if (fire) begin
            pos_reg       <= pos_next;
            travel_reg    <= travel_next;
            dir_neg_reg   <= dir_neg_next;
            last_time_reg <= last_time_next;
            count_reg     <= count_next;
        end
    end

    // Movement arithmetic. In absolute mode the delta is the distance from
    // the tracked position and the new position is the movement itself.
    always_comb begin
        move_ext  = {{(POS_W + 1 - MOVE_W){in_move_reg[MOVE_W-1]}}, in_move_reg};
        pos_ext   = {pos_reg[POS_W-1], pos_reg};
        delta     = in_cmd_reg ? (move_ext - pos_ext) : move_ext;
        pos_sum   = pos_ext + move_ext;
        delta_neg = -delta;
        mag       = delta[POS_W] ? delta_neg[POS_W-1:0] : delta[POS_W-1:0];

        travel_sum = {{(POS_W + 1 - TRAVEL_W){1'b0}}, travel_reg} + {1'b0, mag};
        travel_sat = (travel_sum[POS_W:TRAVEL_W] != '0) ? TRAVEL_MAX
                                                       : travel_sum[TRAVEL_W-1:0];

        // A zero delta is never a reversal.
        reversal = (delta[POS_W] && !dir_neg_reg)
                || (!delta[POS_W] && (delta != '0) && dir_neg_reg);

        // Elapsed time wraps modulo the timestamp width.
        elapsed   = in_time_reg - last_time_reg;
        in_window = elapsed < {{(TIME_W - WINDOW_W){1'b0}}, turn_window_reg};
        count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
    end

    // Next-state logic for one movement word.
    always_comb begin
        pos_next       = pos_reg;
        travel_next    = travel_reg;
        dir_neg_next   = dir_neg_reg;
        last_time_next = last_time_reg;
        count_next     = count_reg;
        shake_next     = 1'b0;

        if (shake_enable_reg) begin
            if (in_cmd_reg) begin
                pos_next = move_ext[POS_W-1:0];
            end else if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
                pos_next = pos_sum[POS_W] ? POS_MIN : POS_MAX;
            end else begin
                pos_next = pos_sum[POS_W-1:0];
            end

            travel_next = travel_sat;

            if (reversal) begin
                dir_neg_next   = !dir_neg_reg;
                last_time_next = in_time_reg;
                if (in_window) begin
                    if (travel_sat > {{(TRAVEL_W - MINTRV_W){1'b0}}, min_travel_reg}) begin
                        travel_next = '0;
                        count_next  = count_inc;
                        // A completed shake keeps the previous reversal time.
                        if (count_inc > turns_needed_reg) begin
                            count_next     = '0;
                            shake_next     = 1'b1;
                            last_time_next = last_time_reg;
                        end
                    end
                end else begin
                    count_next  = '0;
                    travel_next = '0;
                end
            end
        end
    end

    // A disabled detector leaves the tracked state untouched.
    `SGD_ASSERT_NEXT(a_disabled_holds, aclk, aresetn, fire && !shake_enable_reg,
        $stable(pos_reg) && $stable(travel_reg) && $stable(count_reg),
        "state changed while detection was disabled")

    // Reporting a shake restarts the turn count.
    `SGD_ASSERT_NEXT(a_shake_clears_count, aclk, aresetn, fire && shake_next,
        count_reg == '0 && m_valid_reg && m_shaking_reg,
        "shake reported without clearing the turn count")

    // Every evaluated word produces a result word.
    `SGD_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, fire, m_valid_reg,
        "evaluated word produced no result")

    // The input stage never stalls while the result slot can take a word.
    `SGD_ASSERT_NOW(a_ready_when_free, aclk, aresetn, out_free, s_ready,
        "input stalled with a free result slot")

endmodule

`default_nettype wire
